// File: src/ghi_pkg.sv
// ----------------------------------------------------------------------------
// ghi_pkg
// Shared widths, register indexes and stage types for the gyro heading
// integrator.
// ----------------------------------------------------------------------------
package ghi_pkg;

   localparam int GYRO_W    = 16;
   localparam int TIME_W    = 32;
   localparam int DT_W      = 8;
   localparam int HEAD_W    = 35;
   localparam int RATE_W    = 26;
   localparam int BIAS_W    = 25;
   localparam int PROD_W    = RATE_W + DT_W + 1;
   localparam int SUM_W     = HEAD_W + 2;

   localparam int BIAS_COUNT_DEF = 400;

   // one turn per calibration sample: 360 deg * 128 * 1000 ms/s
   localparam longint TURN_PER_SAMPLE = 64'd46080000;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_DT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DT     = 1'd1;

   localparam logic [DT_W-1:0] DEFAULT_DT_RST = 8'd10;
   localparam logic [DT_W-1:0] MAX_DT_RST     = 8'd100;

   // after the front stage: corrected rate and interval
   typedef struct packed {
      logic signed [RATE_W-1:0] rate;
      logic [DT_W-1:0]          dt;
      logic                     zero;
      logic                     cal;
   } front_type;

   // after the multiply stage: heading increment
   typedef struct packed {
      logic signed [PROD_W-1:0] prod;
      logic signed [RATE_W-1:0] rate;
      logic                     zero;
      logic                     cal;
   } mid_type;

endpackage

// File: src/ghi_front.sv
// ----------------------------------------------------------------------------
// ghi_front
// Interval measurement, bias calibration and bias-corrected rate. Holds the
// timestamp, bias and calibration state and the interval registers.
// ----------------------------------------------------------------------------
module ghi_front #(
   parameter int BIAS_COUNT = ghi_pkg::BIAS_COUNT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [ghi_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ghi_pkg::CSR_DATA_W-1:0]      csr_data,
   input  logic                                load,
   input  logic signed [ghi_pkg::GYRO_W-1:0]   gyro_z,
   input  logic [ghi_pkg::TIME_W-1:0]          time_ms,
   input  logic                                zero_request,
   input  logic                                recal_request,
   output ghi_pkg::front_type                  front
);

   localparam int CNT_W = $clog2(BIAS_COUNT + 1);
   localparam logic [CNT_W-1:0] N_CNT = CNT_W'(BIAS_COUNT);
   localparam logic signed [ghi_pkg::RATE_W-1:0] N_RATE = ghi_pkg::RATE_W'(BIAS_COUNT);

   logic [ghi_pkg::DT_W-1:0]            default_dt_ff;
   logic [ghi_pkg::DT_W-1:0]            max_dt_ff;
   logic [ghi_pkg::TIME_W-1:0]          last_time_ff;
   logic signed [ghi_pkg::BIAS_W-1:0]   bias_ff;
   logic signed [ghi_pkg::BIAS_W-1:0]   bias_in;
   logic [CNT_W-1:0]                    count_ff;
   logic [CNT_W-1:0]                    count_in;
   ghi_pkg::front_type                  front_ff;
   ghi_pkg::front_type                  front_in;

   logic [ghi_pkg::TIME_W-1:0]          diff;
   logic [ghi_pkg::TIME_W-1:0]          dt_raw;
   logic [CNT_W-1:0]                    count_eff;
   logic signed [ghi_pkg::BIAS_W-1:0]   bias_eff;

   always_comb begin
      diff = time_ms - last_time_ff;
      if (last_time_ff == '0 || diff == '0) begin
         dt_raw = ghi_pkg::TIME_W'(default_dt_ff);
      end else begin
         dt_raw = diff;
      end
      if (dt_raw > ghi_pkg::TIME_W'(max_dt_ff)) begin
         front_in.dt = max_dt_ff;
      end else begin
         front_in.dt = dt_raw[ghi_pkg::DT_W-1:0];
      end

      count_eff = recal_request ? '0 : count_ff;
      bias_eff  = recal_request ? '0 : bias_ff;
      front_in.zero = zero_request;

      if (count_eff < N_CNT) begin
         // still calibrating: sample goes into the bias sum
         bias_in       = bias_eff + ghi_pkg::BIAS_W'(gyro_z);
         count_in      = count_eff + 1'b1;
         front_in.rate = '0;
         front_in.cal  = (count_in >= N_CNT);
      end else begin
         bias_in       = bias_eff;
         count_in      = count_eff;
         front_in.rate = ghi_pkg::RATE_W'(gyro_z) * N_RATE - ghi_pkg::RATE_W'(bias_eff);
         front_in.cal  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         default_dt_ff <= ghi_pkg::DEFAULT_DT_RST;
         max_dt_ff     <= ghi_pkg::MAX_DT_RST;
         last_time_ff  <= '0;
         bias_ff       <= '0;
         count_ff      <= '0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               ghi_pkg::CSR_DEFAULT_DT: default_dt_ff <= csr_data;
               ghi_pkg::CSR_MAX_DT:     max_dt_ff     <= csr_data;
            endcase
         end
         if (load) begin
            last_time_ff <= time_ms;
            bias_ff      <= bias_in;
            count_ff     <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         front_ff <= front_in;
      end
   end

   assign front = front_ff;

endmodule

// File: src/gyro_heading_integrator.sv
// ----------------------------------------------------------------------------
// gyro_heading_integrator
// Yaw heading from a z-axis rate gyro with start-up bias calibration.
// ----------------------------------------------------------------------------
// Accepts one sample per clock cycle when the result side is not stalled and
// returns one result per sample, in order. The first BIAS_COUNT samples after
// reset or a recalibrate request build the bias sum; after that the heading
// moves by the corrected rate times the timestamp interval and wraps into one
// turn of 360*128*1000*BIAS_COUNT units. Three stages: interval and corrected
// rate, rate times interval, and the heading accumulator, whose add and wrap
// close a loop that limits throughput to one sample per cycle. Stalls back up
// stage by stage, so empty stages keep filling while a result waits. Interval
// registers must be written only while the block is idle; the block itself
// does not enforce it.
// ----------------------------------------------------------------------------
module gyro_heading_integrator #(
   parameter int BIAS_COUNT = ghi_pkg::BIAS_COUNT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [ghi_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ghi_pkg::CSR_DATA_W-1:0]      csr_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [ghi_pkg::GYRO_W-1:0]   req_gyro_z,
   input  logic [ghi_pkg::TIME_W-1:0]          req_time_ms,
   input  logic                                req_zero_request,
   input  logic                                req_recal_request,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ghi_pkg::HEAD_W-1:0]          rsp_heading_fine,
   output logic signed [ghi_pkg::RATE_W-1:0]   rsp_rate_fine,
   output logic                                rsp_calibrated
);

   localparam logic signed [ghi_pkg::SUM_W-1:0] TURN =
      ghi_pkg::SUM_W'(ghi_pkg::TURN_PER_SAMPLE * longint'(BIAS_COUNT));

   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_ready, s2_ready, s1_ready;
   logic accept, s2_load, rsp_load;

   ghi_pkg::front_type front;
   ghi_pkg::mid_type   mid_ff, mid_in;

   logic [ghi_pkg::HEAD_W-1:0]        heading_ff, heading_in;
   logic signed [ghi_pkg::RATE_W-1:0] rate_ff;
   logic                              cal_ff;
   logic [ghi_pkg::HEAD_W-1:0]        base;
   logic signed [ghi_pkg::SUM_W-1:0]  sum, sum_hi, sum_lo;

   // stage handshake
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s2_ready  = !s2_valid_ff || out_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign accept    = req_valid && s1_ready;
   assign s2_load   = s1_valid_ff && s2_ready;
   assign rsp_load  = s2_valid_ff && out_ready;
   assign req_stall = !s1_ready;

   always_comb begin
      s1_valid_in  = accept ? 1'b1 : (s2_ready ? 1'b0 : s1_valid_ff);
      s2_valid_in  = s2_load ? 1'b1 : (out_ready ? 1'b0 : s2_valid_ff);
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   ghi_front #(
      .BIAS_COUNT    (BIAS_COUNT)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .load          (accept),
      .gyro_z        (req_gyro_z),
      .time_ms       (req_time_ms),
      .zero_request  (req_zero_request),
      .recal_request (req_recal_request),
      .front         (front)
   );

   // rate times interval
   always_comb begin
      mid_in.prod = ghi_pkg::PROD_W'(front.rate) *
                    ghi_pkg::PROD_W'(signed'({1'b0, front.dt}));
      mid_in.rate = front.rate;
      mid_in.zero = front.zero;
      mid_in.cal  = front.cal;
   end

   // heading accumulate with a single wrap step
   always_comb begin
      base   = mid_ff.zero ? '0 : heading_ff;
      sum    = signed'(ghi_pkg::SUM_W'(base)) + ghi_pkg::SUM_W'(mid_ff.prod);
      sum_hi = sum - TURN;
      sum_lo = sum + TURN;
      if (sum >= TURN) begin
         heading_in = sum_hi[ghi_pkg::HEAD_W-1:0];
      end else if (sum < 0) begin
         heading_in = sum_lo[ghi_pkg::HEAD_W-1:0];
      end else begin
         heading_in = sum[ghi_pkg::HEAD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         heading_ff   <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (rsp_load) begin
            heading_ff <= heading_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load) begin
         mid_ff <= mid_in;
      end
      if (rsp_load) begin
         rate_ff <= mid_ff.rate;
         cal_ff  <= mid_ff.cal;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_heading_fine = heading_ff;
   assign rsp_rate_fine    = rate_ff;
   assign rsp_calibrated   = cal_ff;

endmodule

// File: src/ghi_checker.sv
// ----------------------------------------------------------------------------
// ghi_checker
// Port-level checks for the gyro heading integrator, bound to the top level.
// ----------------------------------------------------------------------------
module ghi_checker #(
   parameter int BIAS_COUNT = ghi_pkg::BIAS_COUNT_DEF
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [ghi_pkg::HEAD_W-1:0]          rsp_heading_fine,
   input logic signed [ghi_pkg::RATE_W-1:0]   rsp_rate_fine,
   input logic                                rsp_calibrated
);

   localparam logic [ghi_pkg::HEAD_W-1:0] TURN =
      ghi_pkg::HEAD_W'(ghi_pkg::TURN_PER_SAMPLE * longint'(BIAS_COUNT));

   // a waiting result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_heading_fine)
         && $stable(rsp_rate_fine) && $stable(rsp_calibrated))
      else $error("result changed while stalled");

   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_heading_fine < TURN)
      else $error("heading outside one turn");

   // no corrected rate before the bias is known
   a_rate_uncal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_calibrated |-> rsp_rate_fine == '0)
      else $error("nonzero rate while calibrating");

   // nothing can come out the cycle after reset, and input is open when empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      $past(reset) && !req_valid |=> !rsp_valid)
      else $error("result without a transaction");

endmodule

bind gyro_heading_integrator ghi_checker #(
   .BIAS_COUNT (BIAS_COUNT)
) u_ghi_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_heading_fine (rsp_heading_fine),
   .rsp_rate_fine    (rsp_rate_fine),
   .rsp_calibrated   (rsp_calibrated)
);
